FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the ball step block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bbs_pkg.sv
// Constants for the bouncing ball step block: defaults, register map, reset values.
package bbs_pkg;

  // default fixed-point format
  localparam int FRAC_BITS_DEF = 8;
  localparam int POS_WIDTH_DEF = 24;

  // field widths
  localparam int DT_W      = 16;
  localparam int PTR_W     = 12;
  localparam int SCREEN_W  = 12;
  localparam int RADIUS_W  = 10;
  localparam int FACTOR_W  = 9;
  localparam int GRAVITY_W = 16;
  localparam int GAIN_W    = 8;
  localparam int BALL_W    = 24;
  localparam int SPEED_W   = 32;

  // channel widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 1;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS        = 3'd2;
  localparam logic [2:0] REG_ELASTICITY    = 3'd3;
  localparam logic [2:0] REG_FRICTION      = 3'd4;
  localparam logic [2:0] REG_GRAVITY_STEP  = 3'd5;
  localparam logic [2:0] REG_THROW_GAIN    = 3'd6;

  // register reset values
  localparam logic [SCREEN_W-1:0]  RST_SCREEN_WIDTH  = 12'd800;
  localparam logic [SCREEN_W-1:0]  RST_SCREEN_HEIGHT = 12'd600;
  localparam logic [RADIUS_W-1:0]  RST_RADIUS        = 10'd50;
  localparam logic [FACTOR_W-1:0]  RST_ELASTICITY    = 9'd230;
  localparam logic [FACTOR_W-1:0]  RST_FRICTION      = 9'd256;
  localparam logic [GRAVITY_W-1:0] RST_GRAVITY_STEP  = 16'd2560;
  localparam logic [GAIN_W-1:0]    RST_THROW_GAIN    = 8'd100;

  // ball reset state in whole pixels
  localparam int RST_CENTRE_X_PIX = 400;
  localparam int RST_CENTRE_Y_PIX = 300;
  localparam int RST_VEL_PIX      = 200;

  // rounding and scaling
  localparam int FRAME_SHIFT = 16;
  localparam int Q8_SHIFT    = 8;
  localparam int Q8_ROUND    = 128;

endpackage

FILE: hw/rtl/bouncing_ball_step.sv
// Bouncing ball physics step: one ball advanced by one frame per input transaction.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready     | tdata: frame_time, pointer_x, pointer_y
//          |     |                           | tuser: button_pressed, button_released
//  out_    | out | out_tvalid / out_tready   | tdata: ball_x, ball_y, speed_x, speed_y
//          |     |                           | tuser: held
//  cfg_    | in  | APB write, pready = 1     | seven registers at byte address 4*i
//
// A dragged ball with no press only follows the pointer, and a release throws it; a free
// ball is moved, wall-tested, bounced on a hit and slowed on each axis, and a press adds
// a grab test. A sequencer runs every multiply through one shared multiplier (one
// product per cycle, registered) and every add, clamp and wall test through the step after it.
// in_tready is high only while the sequencer is idle. A finished result waits in the
// output register; the next item is taken meanwhile and stalls only at its own end.
// Reset is synchronous; there is no clearing pass.
`include "assert_macros.svh"

module bouncing_ball_step #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF,
  parameter int POS_WIDTH = bbs_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // frame_time[15:0], pointer_x[27:16], pointer_y[39:28]
  input  logic [bbs_pkg::IN_DATA_W-1:0]   in_tdata,
  // button_pressed[0], button_released[1]
  input  logic [bbs_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ball_x[23:0], ball_y[47:24], speed_x[79:48], speed_y[111:80]
  output logic [bbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // held[0]
  output logic [bbs_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bbs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int F   = FRAC_BITS;
  localparam int P   = POS_WIDTH;
  localparam int VW  = bbs_pkg::SPEED_W;
  localparam int RW  = bbs_pkg::RADIUS_W + F;
  localparam int AW  = ((P > VW) ? P : VW) + 2;
  localparam int BW  = ((RW + 1) > (bbs_pkg::DT_W + 1)) ? (RW + 1) : (bbs_pkg::DT_W + 1);
  localparam int PW  = AW + BW;
  localparam int XW  = PW + 2;
  localparam int OW  = bbs_pkg::BALL_W;

  localparam logic signed [XW-1:0] P_MAX = XW'((64'sd1 <<< (P - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] P_MIN = -P_MAX - XW'(1);
  localparam logic signed [XW-1:0] V_MAX = XW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] V_MIN = -V_MAX - XW'(1);
  localparam logic signed [XW-1:0] O_MAX = XW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] O_MIN = -O_MAX - XW'(1);
  localparam logic signed [XW-1:0] ROUND_X = XW'(bbs_pkg::Q8_ROUND);
  localparam logic signed [XW-1:0] CX_RST = XW'(bbs_pkg::RST_CENTRE_X_PIX) <<< F;
  localparam logic signed [XW-1:0] CY_RST = XW'(bbs_pkg::RST_CENTRE_Y_PIX) <<< F;
  localparam logic signed [VW-1:0] VEL_RST = VW'(bbs_pkg::RST_VEL_PIX) <<< F;

  // sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MDT  = 5'd1;   // velocity * frame time
  localparam logic [4:0] ST_ADD  = 5'd2;   // move
  localparam logic [4:0] ST_WALL = 5'd3;   // wall test and clamp
  localparam logic [4:0] ST_MBNC = 5'd4;   // -velocity * elasticity
  localparam logic [4:0] ST_BNCW = 5'd5;
  localparam logic [4:0] ST_MFRC = 5'd6;   // velocity * friction
  localparam logic [4:0] ST_FRCW = 5'd7;
  localparam logic [4:0] ST_DRAG = 5'd8;
  localparam logic [4:0] ST_DIFF = 5'd9;   // distance to pointer
  localparam logic [4:0] ST_RSQ  = 5'd10;
  localparam logic [4:0] ST_SQX  = 5'd11;
  localparam logic [4:0] ST_SQY  = 5'd12;
  localparam logic [4:0] ST_CMP  = 5'd13;
  localparam logic [4:0] ST_GRAB = 5'd14;
  localparam logic [4:0] ST_RMUL = 5'd15;  // displacement * gain
  localparam logic [4:0] ST_RELW = 5'd16;
  localparam logic [4:0] ST_FIN  = 5'd17;

  function automatic logic signed [P-1:0] sat_p(input logic signed [XW-1:0] v);
    if (v > P_MAX) return P_MAX[P-1:0];
    if (v < P_MIN) return P_MIN[P-1:0];
    return v[P-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_v(input logic signed [XW-1:0] v);
    if (v > V_MAX) return V_MAX[VW-1:0];
    if (v < V_MIN) return V_MIN[VW-1:0];
    return v[VW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sat_o(input logic signed [XW-1:0] v);
    if (v > O_MAX) return O_MAX[OW-1:0];
    if (v < O_MIN) return O_MIN[OW-1:0];
    return v[OW-1:0];
  endfunction

  // configuration
  logic [bbs_pkg::SCREEN_W-1:0]  cfg_w_r, cfg_h_r;
  logic [bbs_pkg::RADIUS_W-1:0]  cfg_r_r;
  logic [bbs_pkg::FACTOR_W-1:0]  cfg_e_r, cfg_f_r;
  logic [bbs_pkg::GRAVITY_W-1:0] cfg_g_r;
  logic [bbs_pkg::GAIN_W-1:0]    cfg_gain_r;
  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  // control and ball state
  logic [4:0]             state_r, state_nxt, post_state;
  logic                   ax_r, ax_nxt;
  logic                   far_r, far_nxt;
  logic                   drag_r, drag_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [P-1:0]    pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [VW-1:0]   vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic signed [P-1:0]    grab_x_r, grab_x_nxt, grab_y_r, grab_y_nxt;
  logic signed [P-1:0]    last_x_r, last_x_nxt, last_y_r, last_y_nxt;

  // payload
  logic [bbs_pkg::DT_W-1:0]        dt_r;
  logic [bbs_pkg::PTR_W-1:0]       ptx_r, pty_r;
  logic                            press_r, rel_r;
  logic [RW-1:0]                   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [2*RW-1:0]                 rsq_r, rsq_nxt, acc_r, acc_nxt;
  logic signed [PW-1:0]            prod_r;
  logic signed [AW-1:0]            mul_a;
  logic signed [BW-1:0]            mul_b;
  logic [bbs_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                            out_held_r, out_held_nxt;

  // current-axis views
  logic signed [P-1:0]           pos_c, grab_c, last_c;
  logic signed [VW-1:0]          vel_c;
  logic [bbs_pkg::PTR_W-1:0]     ptr_c;
  logic [bbs_pkg::SCREEN_W-1:0]  size_c;
  logic [RW-1:0]                 r_w;
  logic signed [XW-1:0]          pos_cx, grab_cx, ptr_cx, r_x, s_x, prod_x;
  logic signed [XW-1:0]          step_x, q8_x, diff_x, abs_x, hi_x, lo_x, g_x;
  logic                          hit_hi, hit_lo, in_acc;
  logic [2*RW:0]                 sq_sum;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      bbs_pkg::REG_SCREEN_WIDTH:  cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_w_r);
      bbs_pkg::REG_SCREEN_HEIGHT: cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_h_r);
      bbs_pkg::REG_RADIUS:        cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_r_r);
      bbs_pkg::REG_ELASTICITY:    cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_e_r);
      bbs_pkg::REG_FRICTION:      cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_f_r);
      bbs_pkg::REG_GRAVITY_STEP:  cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_g_r);
      bbs_pkg::REG_THROW_GAIN:    cfg_prdata = bbs_pkg::CFG_DATA_W'(cfg_gain_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= bbs_pkg::RST_SCREEN_WIDTH;
      cfg_h_r    <= bbs_pkg::RST_SCREEN_HEIGHT;
      cfg_r_r    <= bbs_pkg::RST_RADIUS;
      cfg_e_r    <= bbs_pkg::RST_ELASTICITY;
      cfg_f_r    <= bbs_pkg::RST_FRICTION;
      cfg_g_r    <= bbs_pkg::RST_GRAVITY_STEP;
      cfg_gain_r <= bbs_pkg::RST_THROW_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bbs_pkg::REG_SCREEN_WIDTH:  cfg_w_r    <= cfg_pwdata[bbs_pkg::SCREEN_W-1:0];
        bbs_pkg::REG_SCREEN_HEIGHT: cfg_h_r    <= cfg_pwdata[bbs_pkg::SCREEN_W-1:0];
        bbs_pkg::REG_RADIUS:        cfg_r_r    <= cfg_pwdata[bbs_pkg::RADIUS_W-1:0];
        bbs_pkg::REG_ELASTICITY:    cfg_e_r    <= cfg_pwdata[bbs_pkg::FACTOR_W-1:0];
        bbs_pkg::REG_FRICTION:      cfg_f_r    <= cfg_pwdata[bbs_pkg::FACTOR_W-1:0];
        bbs_pkg::REG_GRAVITY_STEP:  cfg_g_r    <= cfg_pwdata[bbs_pkg::GRAVITY_W-1:0];
        bbs_pkg::REG_THROW_GAIN:    cfg_gain_r <= cfg_pwdata[bbs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_held_r;

  assign pos_c  = ax_r ? pos_y_r  : pos_x_r;
  assign vel_c  = ax_r ? vel_y_r  : vel_x_r;
  assign grab_c = ax_r ? grab_y_r : grab_x_r;
  assign last_c = ax_r ? last_y_r : last_x_r;
  assign ptr_c  = ax_r ? pty_r    : ptx_r;
  assign size_c = ax_r ? cfg_h_r  : cfg_w_r;
  assign r_w    = {cfg_r_r, {F{1'b0}}};

  assign pos_cx  = XW'(pos_c);
  assign grab_cx = XW'(grab_c);
  assign ptr_cx  = XW'({ptr_c, {F{1'b0}}});
  assign r_x     = XW'(r_w);
  assign s_x     = XW'({size_c, {F{1'b0}}});
  assign prod_x  = XW'(prod_r);
  assign step_x  = prod_x >>> bbs_pkg::FRAME_SHIFT;
  assign q8_x    = (prod_x + ROUND_X) >>> bbs_pkg::Q8_SHIFT;
  assign diff_x  = pos_cx - ptr_cx;
  assign abs_x   = diff_x[XW-1] ? -diff_x : diff_x;
  assign hi_x    = pos_cx + r_x;
  assign lo_x    = pos_cx - r_x;
  assign hit_hi  = hi_x > s_x;
  assign hit_lo  = lo_x[XW-1];
  assign g_x     = ax_r ? XW'(cfg_g_r) : '0;
  assign sq_sum  = {1'b0, acc_r} + {1'b0, prod_r[2*RW-1:0]};

  // after the motion update: press test has priority over release
  assign post_state = press_r ? ST_DIFF : ((rel_r && drag_r) ? ST_RMUL : ST_FIN);

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    far_nxt       = far_r;
    drag_nxt      = drag_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    grab_x_nxt    = grab_x_r;
    grab_y_nxt    = grab_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    rsq_nxt       = rsq_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_held_nxt  = out_held_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt    = 1'b0;
          far_nxt   = 1'b0;
          state_nxt = drag_r ? ST_DRAG : ST_MDT;
        end
      end
      ST_MDT: begin
        mul_a     = AW'(vel_c);
        mul_b     = BW'(dt_r);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (ax_r) pos_y_nxt = sat_p(pos_cx + step_x);
        else      pos_x_nxt = sat_p(pos_cx + step_x);
        state_nxt = ST_WALL;
      end
      ST_WALL: begin
        // right/bottom wall first, then left/top
        if (hit_hi) begin
          if (ax_r) pos_y_nxt = sat_p(s_x - r_x);
          else      pos_x_nxt = sat_p(s_x - r_x);
          state_nxt = ST_MBNC;
        end else if (hit_lo) begin
          if (ax_r) pos_y_nxt = sat_p(r_x);
          else      pos_x_nxt = sat_p(r_x);
          state_nxt = ST_MBNC;
        end else begin
          state_nxt = ST_MFRC;
        end
      end
      ST_MBNC: begin
        mul_a     = -AW'(vel_c);
        mul_b     = BW'(cfg_e_r);
        state_nxt = ST_BNCW;
      end
      ST_BNCW: begin
        if (ax_r) vel_y_nxt = sat_v(q8_x);
        else      vel_x_nxt = sat_v(q8_x);
        state_nxt = ST_MFRC;
      end
      ST_MFRC: begin
        mul_a     = AW'(vel_c);
        mul_b     = BW'(cfg_f_r);
        state_nxt = ST_FRCW;
      end
      ST_FRCW: begin
        // gravity only on the vertical axis
        if (ax_r) vel_y_nxt = sat_v(q8_x + g_x);
        else      vel_x_nxt = sat_v(q8_x + g_x);
        if (ax_r) begin
          ax_nxt    = 1'b0;
          state_nxt = post_state;
        end else begin
          ax_nxt    = 1'b1;
          state_nxt = ST_MDT;
        end
      end
      ST_DRAG: begin
        if (ax_r) pos_y_nxt = sat_p(ptr_cx - grab_cx);
        else      pos_x_nxt = sat_p(ptr_cx - grab_cx);
        ax_nxt = ~ax_r;
        if (ax_r) state_nxt = post_state;
      end
      ST_DIFF: begin
        // anything farther than one radius on an axis is outside
        if (abs_x > r_x) far_nxt = 1'b1;
        if (ax_r) dy_nxt = abs_x[RW-1:0];
        else      dx_nxt = abs_x[RW-1:0];
        ax_nxt = ~ax_r;
        if (ax_r) state_nxt = ST_RSQ;
      end
      ST_RSQ: begin
        mul_a     = AW'(r_w);
        mul_b     = BW'(r_w);
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        rsq_nxt   = prod_r[2*RW-1:0];
        mul_a     = AW'(dx_r);
        mul_b     = BW'(dx_r);
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        acc_nxt   = prod_r[2*RW-1:0];
        mul_a     = AW'(dy_r);
        mul_b     = BW'(dy_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!far_r && (sq_sum <= {1'b0, rsq_r})) begin
          drag_nxt  = 1'b1;
          ax_nxt    = 1'b0;
          state_nxt = ST_GRAB;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_GRAB: begin
        if (ax_r) grab_y_nxt = sat_p(ptr_cx - pos_cx);
        else      grab_x_nxt = sat_p(ptr_cx - pos_cx);
        ax_nxt = ~ax_r;
        if (ax_r) state_nxt = ST_FIN;
      end
      ST_RMUL: begin
        mul_a     = AW'(pos_c) - AW'(last_c);
        mul_b     = BW'(cfg_gain_r);
        state_nxt = ST_RELW;
      end
      ST_RELW: begin
        if (ax_r) vel_y_nxt = sat_v(prod_x);
        else      vel_x_nxt = sat_v(prod_x);
        ax_nxt = ~ax_r;
        if (ax_r) begin
          drag_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RMUL;
        end
      end
      ST_FIN: begin
        // hold here while the previous result is still waiting
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {vel_y_r, vel_x_r, sat_o(XW'(pos_y_r)), sat_o(XW'(pos_x_r))};
          out_held_nxt  = drag_r;
          out_valid_nxt = 1'b1;
          last_x_nxt    = pos_x_r;
          last_y_nxt    = pos_y_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= 1'b0;
      far_r       <= 1'b0;
      drag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= sat_p(CX_RST);
      pos_y_r     <= sat_p(CY_RST);
      vel_x_r     <= VEL_RST;
      vel_y_r     <= VEL_RST;
      grab_x_r    <= '0;
      grab_y_r    <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      far_r       <= far_nxt;
      drag_r      <= drag_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      grab_x_r    <= grab_x_nxt;
      grab_y_r    <= grab_y_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r    <= in_tdata[15:0];
      ptx_r   <= in_tdata[27:16];
      pty_r   <= in_tdata[39:28];
      press_r <= in_tuser[0];
      rel_r   <= in_tuser[1];
    end
    prod_r     <= mul_a * mul_b;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    rsq_r      <= rsq_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_held_r <= out_held_nxt;
  end

  `BBS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready)
  `BBS_ASSERT_IMP(a_held_matches_state, clk, rst_n,
                  (state_r == ST_IDLE) && out_valid_r, out_held_r == drag_r)
  `BBS_ASSERT_NXT(a_far_never_grabs, clk, rst_n,
                  (state_r == ST_CMP) && far_r, drag_r == $past(drag_r))
  `BBS_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule
